FILE: src/fdo_pkg.sv
// ---------------------------------------------------------------------------
// fdo_pkg: shared types and constants of the frame-rate digit overlay
// Register indexes, configuration bundle, glyph ROM and field widths used by
// the front end, the rectangle emitter, the top level and the checker.
// ---------------------------------------------------------------------------
package fdo_pkg;

  // Field widths
  localparam int COORD_W   = 11;
  localparam int OY_W      = 10;
  localparam int CELL_W    = 4;
  localparam int WIN_W     = 16;
  localparam int COLOR_W   = 32;
  localparam int TIME_W    = 32;
  localparam int FRAMES_W  = 16;
  localparam int RATE_W    = 10;
  localparam int DIGIT_W   = 4;

  // Rate arithmetic
  localparam int RATE_SCALE = 1000;
  localparam int RATE_MAX   = 999;
  localparam int DVD_W      = 26;  // 65535 * 1000 fits in 26 bits
  localparam int STEP_W     = 5;

  // Glyph geometry
  localparam int GLYPH_ROWS = 5;
  localparam int GLYPH_COLS = 3;
  localparam int NUM_DIGITS = 3;

  // Queue between front end and emitter
  localparam int QUEUE_DEPTH = 2;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 88;  // 86 bits of fields, padded to bytes

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANCHOR_X   = 3'd0,
    REG_ANCHOR_Y   = 3'd1,
    REG_CELL_SIZE  = 3'd2,
    REG_WINDOW_MS  = 3'd3,
    REG_DRAW_COLOR = 3'd4
  } reg_index_t;

  // Reset values of the registers
  localparam logic [COORD_W-1:0] ANCHOR_X_RST   = 11'd20;
  localparam logic [OY_W-1:0]    ANCHOR_Y_RST   = 10'd20;
  localparam logic [CELL_W-1:0]  CELL_SIZE_RST  = 4'd3;
  localparam logic [WIN_W-1:0]   WINDOW_MS_RST  = 16'd1000;
  localparam logic [COLOR_W-1:0] DRAW_COLOR_RST = 32'hFF00FF00;

  typedef struct packed {
    logic [COORD_W-1:0] anchor_x;
    logic [OY_W-1:0]    anchor_y;
    logic [CELL_W-1:0]  cell_size;
    logic [WIN_W-1:0]   window_ms;
    logic [COLOR_W-1:0] draw_color;
  } cfg_t;

  // 3x5 digit glyphs, top row in bits [14:12], leftmost column as MSB of a row
  localparam logic [14:0] GLYPH_ROM [10] = '{
    15'b111_101_101_101_111,
    15'b010_110_010_010_111,
    15'b111_001_111_100_111,
    15'b111_001_111_001_111,
    15'b101_101_111_001_001,
    15'b111_100_111_001_111,
    15'b111_100_111_101_111,
    15'b111_001_001_001_001,
    15'b111_101_111_101_111,
    15'b111_101_111_001_111
  };

  // Look up one cell of a digit glyph
  function automatic logic glyph_lit(input logic [DIGIT_W-1:0] digit,
                                     input logic [2:0] row,
                                     input logic [1:0] col);
    logic [14:0] g;
    logic [2:0]  bits;
    logic        lit;
    g = (digit < 4'd10) ? GLYPH_ROM[digit] : '0;
    case (row)
      3'd0:    bits = g[14:12];
      3'd1:    bits = g[11:9];
      3'd2:    bits = g[8:6];
      3'd3:    bits = g[5:3];
      3'd4:    bits = g[2:0];
      default: bits = '0;
    endcase
    case (col)
      2'd0:    lit = bits[2];
      2'd1:    lit = bits[1];
      2'd2:    lit = bits[0];
      default: lit = 1'b0;
    endcase
    return lit;
  endfunction

endpackage

FILE: src/fdo_front.sv
// ---------------------------------------------------------------------------
// fdo_front: frame counting and rate sampling
// Accepts one frame event, updates the frame counter and sample time, runs a
// bit-serial restoring division when the window has elapsed, and queues the
// rate to be drawn.
// ---------------------------------------------------------------------------
module fdo_front (
  input  logic                           clk,
  input  logic                           rst,
  input  fdo_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fdo_pkg::TIME_W-1:0]     now_ms,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [fdo_pkg::RATE_W-1:0]     q_data
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_EVAL = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t                     state;
  logic [fdo_pkg::TIME_W-1:0]       now_reg;
  logic [fdo_pkg::TIME_W-1:0]       sample_time;
  logic [fdo_pkg::FRAMES_W-1:0]     frames_seen;
  logic [fdo_pkg::RATE_W-1:0]       rate_value;
  logic [fdo_pkg::TIME_W-1:0]       divisor;
  logic [fdo_pkg::TIME_W:0]         rem;
  logic [fdo_pkg::DVD_W-1:0]        quo;
  logic [fdo_pkg::STEP_W-1:0]       step;

  logic [fdo_pkg::FRAMES_W-1:0]     frames_inc;
  logic [fdo_pkg::TIME_W-1:0]       start_time;
  logic [fdo_pkg::TIME_W-1:0]       elapsed;
  logic [fdo_pkg::WIN_W-1:0]        win;
  logic                             resample;
  logic [fdo_pkg::DVD_W-1:0]        product;
  logic [fdo_pkg::TIME_W:0]         trial;
  logic                             trial_ge;
  logic [fdo_pkg::TIME_W:0]         rem_next;
  logic [fdo_pkg::DVD_W-1:0]        quo_next;

  assign in_ready = (state == F_IDLE);
  assign q_push   = (state == F_PUSH) && !q_full;
  assign q_data   = rate_value;

  // Evaluate the frame event held in now_reg
  always_comb begin
    frames_inc = (frames_seen == '1) ? frames_seen : frames_seen + 1'b1;
    start_time = (sample_time == '0) ? now_reg : sample_time;
    elapsed    = now_reg - start_time;
    win        = (cfg.window_ms == '0) ? fdo_pkg::WIN_W'(1) : cfg.window_ms;
    resample   = elapsed >= {{(fdo_pkg::TIME_W-fdo_pkg::WIN_W){1'b0}}, win};
    product    = fdo_pkg::DVD_W'(frames_inc) * fdo_pkg::DVD_W'(fdo_pkg::RATE_SCALE);
  end

  // One restoring division step per cycle
  always_comb begin
    trial    = {rem[fdo_pkg::TIME_W-1:0], quo[fdo_pkg::DVD_W-1]};
    trial_ge = trial >= {1'b0, divisor};
    rem_next = trial_ge ? (trial - {1'b0, divisor}) : trial;
    quo_next = {quo[fdo_pkg::DVD_W-2:0], trial_ge};
  end

  // Control state and sampling state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      sample_time <= '0;
      frames_seen <= '0;
      rate_value  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) state <= F_EVAL;
        end
        F_EVAL: begin
          if (resample) begin
            frames_seen <= '0;
            sample_time <= now_reg;
            state       <= F_DIV;
          end else begin
            frames_seen <= frames_inc;
            sample_time <= start_time;
            state       <= F_PUSH;
          end
        end
        F_DIV: begin
          if (step == '0) begin
            rate_value <= (quo_next > fdo_pkg::DVD_W'(fdo_pkg::RATE_MAX)) ?
                          fdo_pkg::RATE_W'(fdo_pkg::RATE_MAX) :
                          quo_next[fdo_pkg::RATE_W-1:0];
            state      <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Event capture and divider datapath
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) now_reg <= now_ms;
    if (state == F_EVAL) begin
      quo     <= product;
      rem     <= '0;
      divisor <= elapsed;
      step    <= fdo_pkg::STEP_W'(fdo_pkg::DVD_W - 1);
    end else if (state == F_DIV) begin
      quo  <= quo_next;
      rem  <= rem_next;
      step <= step - 1'b1;
    end
  end

endmodule

FILE: src/fdo_queue.sv
// ---------------------------------------------------------------------------
// fdo_queue: rate queue between front end and emitter
// Small first-in first-out buffer of rates still to be drawn.
// ---------------------------------------------------------------------------
module fdo_queue #(
  parameter int DEPTH = fdo_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [fdo_pkg::RATE_W-1:0]  push_data,
  output logic                        full,
  input  logic                        pop,
  output logic [fdo_pkg::RATE_W-1:0]  pop_data,
  output logic                        empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [fdo_pkg::RATE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]           wr_ptr;
  logic [PTR_W-1:0]           rd_ptr;
  logic [CNT_W-1:0]           count;
  logic                       do_push;
  logic                       do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/fdo_back.sv
// ---------------------------------------------------------------------------
// fdo_back: glyph rectangle emitter
// Splits a queued rate into decimal digits and scans the glyph cells of the
// drawn digits, one cell per cycle while the output is not stalled, loading a
// rectangle for every lit cell into the output register.
// ---------------------------------------------------------------------------
module fdo_back (
  input  logic                              clk,
  input  logic                              rst,
  input  fdo_pkg::cfg_t                     cfg,
  input  logic                              q_empty,
  input  logic [fdo_pkg::RATE_W-1:0]        q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fdo_pkg::OUT_TDATA_W-1:0]   out_data,
  output logic                              out_last
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_HUND = 4'b0010,
    B_TENS = 4'b0100,
    B_SCAN = 4'b1000
  } back_state_t;

  localparam int PAD_W = fdo_pkg::OUT_TDATA_W - 4 * fdo_pkg::COORD_W
                         - fdo_pkg::COLOR_W - fdo_pkg::RATE_W;

  back_state_t                     state;
  logic [fdo_pkg::RATE_W-1:0]      rate_reg;
  logic [fdo_pkg::DIGIT_W-1:0]     hund;
  logic [fdo_pkg::DIGIT_W-1:0]     tens;
  logic [fdo_pkg::DIGIT_W-1:0]     units;
  logic [6:0]                      rem100;
  logic [1:0]                      digit_idx;
  logic [2:0]                      row;
  logic [1:0]                      col;
  logic [fdo_pkg::COORD_W-1:0]     xbase;
  logic [fdo_pkg::COORD_W-1:0]     left;
  logic [fdo_pkg::COORD_W-1:0]     top;

  logic [fdo_pkg::COORD_W-1:0]     o_left;
  logic [fdo_pkg::COORD_W-1:0]     o_top;
  logic [fdo_pkg::COORD_W-1:0]     o_right;
  logic [fdo_pkg::COORD_W-1:0]     o_bottom;
  logic [fdo_pkg::COLOR_W-1:0]     o_color;
  logic [fdo_pkg::RATE_W-1:0]      o_rate;

  logic [15:0]                     hund_prod;
  logic [14:0]                     tens_prod;
  logic [3:0]                      tens_q;
  logic [fdo_pkg::COORD_W-1:0]     cell_px;
  logic [fdo_pkg::COORD_W-1:0]     pitch;
  logic [fdo_pkg::COORD_W-1:0]     start_off;
  logic [fdo_pkg::COORD_W-1:0]     oy;
  logic [fdo_pkg::DIGIT_W-1:0]     cur_digit;
  logic                            lit;
  logic                            scan_go;
  logic                            final_cell;
  logic                            row_end;
  logic                            col_end;

  // Constant divisions by 100 and 10 through reciprocal multiplies
  always_comb begin
    hund_prod = 16'(rate_reg) * 16'd41;
    tens_prod = 15'(rem100) * 15'd205;
    tens_q    = tens_prod[14:11];
  end

  // Geometry of the glyph grid
  always_comb begin
    cell_px = fdo_pkg::COORD_W'(cfg.cell_size);
    pitch   = (cell_px << 2) + cell_px;
    oy      = fdo_pkg::COORD_W'(cfg.anchor_y);
    if (rate_reg >= 10'd100)     start_off = '0;
    else if (rate_reg >= 10'd10) start_off = pitch;
    else                         start_off = pitch << 1;
  end

  // Current cell
  always_comb begin
    case (digit_idx)
      2'd0:    cur_digit = hund;
      2'd1:    cur_digit = tens;
      default: cur_digit = units;
    endcase
    lit     = fdo_pkg::glyph_lit(cur_digit, row, col);
    col_end = (col == 2'(fdo_pkg::GLYPH_COLS - 1));
    row_end = (row == 3'(fdo_pkg::GLYPH_ROWS - 1));
    // every glyph lights its bottom-right cell, so that cell of the units
    // digit is the final rectangle of the frame
    final_cell = (digit_idx == 2'(fdo_pkg::NUM_DIGITS - 1)) && row_end && col_end;
  end

  assign scan_go  = (state == B_SCAN) && (!out_valid || out_ready);
  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign out_data = {{PAD_W{1'b0}}, o_rate, o_color, o_bottom, o_right, o_top, o_left};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_empty) state <= B_HUND;
        end
        B_HUND: state <= B_TENS;
        B_TENS: state <= B_SCAN;
        B_SCAN: begin
          if (scan_go && final_cell) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Digit split and cell scan datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) rate_reg <= q_data;
      end
      B_HUND: begin
        hund   <= hund_prod[15:12];
        rem100 <= 7'(rate_reg - 10'(hund_prod[15:12]) * 10'd100);
      end
      B_TENS: begin
        tens      <= tens_q;
        units     <= 4'(rem100 - 7'(tens_q) * 7'd10);
        row       <= '0;
        col       <= '0;
        top       <= oy;
        xbase     <= cfg.anchor_x + start_off;
        left      <= cfg.anchor_x + start_off;
        if (rate_reg >= 10'd100)     digit_idx <= 2'd0;
        else if (rate_reg >= 10'd10) digit_idx <= 2'd1;
        else                         digit_idx <= 2'(fdo_pkg::NUM_DIGITS - 1);
      end
      B_SCAN: begin
        if (scan_go) begin
          if (!col_end) begin
            col  <= col + 1'b1;
            left <= left + cell_px;
          end else begin
            col <= '0;
            if (!row_end) begin
              row  <= row + 1'b1;
              top  <= top + cell_px;
              left <= xbase;
            end else begin
              row       <= '0;
              top       <= oy;
              digit_idx <= digit_idx + 1'b1;
              xbase     <= xbase + pitch;
              left      <= xbase + pitch;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: hold until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_go && lit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go && lit) begin
      o_left   <= left;
      o_top    <= top;
      o_right  <= left + cell_px;
      o_bottom <= top + cell_px;
      o_color  <= cfg.draw_color;
      o_rate   <= rate_reg;
      out_last <= final_cell;
    end
  end

endmodule

FILE: src/fps_digit_overlay_generator.sv
// ---------------------------------------------------------------------------
// fps_digit_overlay_generator: frame-rate digit overlay
// Counts frame events, resamples the frame rate once per window and emits one
// rectangle per lit glyph cell of the rate's digits, without leading zeros.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      now_ms
//   m_axis    out  m_axis_tvalid/tready      rectangle fields, tlast = last_rect
//   cfg       in   cfg_wr_en                 cfg_index, cfg_data
//
// Front end: idle, evaluate, a 26-step bit-serial division when the window
// elapses, then a push into the rate queue. Emitter: setup in the idle,
// hundreds and tens states, then a scan of every cell of each drawn digit's
// 3x5 glyph. Output stalls freeze the scan; a full rate queue holds off
// s_axis_tready. Reset needs no clearing pass.
// ---------------------------------------------------------------------------
module fps_digit_overlay_generator #(
  parameter int QUEUE_DEPTH = fdo_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fdo_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [31:0] now_ms
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [10:0] rect_left, [21:11] rect_top, [32:22] rect_right,
  // [43:33] rect_bottom, [75:44] rect_color, [85:76] shown_rate, [87:86] zero
  output logic [fdo_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,   // last_rect
  input  logic                                cfg_wr_en,
  input  logic [fdo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdo_pkg::CFG_DATA_W-1:0]      cfg_data
);

  fdo_pkg::cfg_t              cfg;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_push;
  logic                       q_pop;
  logic [fdo_pkg::RATE_W-1:0] q_in;
  logic [fdo_pkg::RATE_W-1:0] q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.anchor_x   <= fdo_pkg::ANCHOR_X_RST;
      cfg.anchor_y   <= fdo_pkg::ANCHOR_Y_RST;
      cfg.cell_size  <= fdo_pkg::CELL_SIZE_RST;
      cfg.window_ms  <= fdo_pkg::WINDOW_MS_RST;
      cfg.draw_color <= fdo_pkg::DRAW_COLOR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fdo_pkg::REG_ANCHOR_X:   cfg.anchor_x   <= cfg_data[fdo_pkg::COORD_W-1:0];
        fdo_pkg::REG_ANCHOR_Y:   cfg.anchor_y   <= cfg_data[fdo_pkg::OY_W-1:0];
        fdo_pkg::REG_CELL_SIZE:  cfg.cell_size  <= cfg_data[fdo_pkg::CELL_W-1:0];
        fdo_pkg::REG_WINDOW_MS:  cfg.window_ms  <= cfg_data[fdo_pkg::WIN_W-1:0];
        fdo_pkg::REG_DRAW_COLOR: cfg.draw_color <= cfg_data[fdo_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  fdo_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .now_ms   (s_axis_tdata[fdo_pkg::TIME_W-1:0]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  fdo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  fdo_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: src/fdo_checker.sv
// ---------------------------------------------------------------------------
// fdo_checker: port-level checks of the digit overlay
// Watches the stream ports for reset behavior, rectangle shape, rate range
// and output hold under backpressure.
// ---------------------------------------------------------------------------
module fdo_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [fdo_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                              m_axis_tlast
);

  logic [10:0] left;
  logic [10:0] top;
  logic [10:0] right;
  logic [10:0] bottom;
  logic [9:0]  rate;

  assign left   = m_axis_tdata[10:0];
  assign top    = m_axis_tdata[21:11];
  assign right  = m_axis_tdata[32:22];
  assign bottom = m_axis_tdata[43:33];
  assign rate   = m_axis_tdata[85:76];

  // Reset leaves no rectangle pending and the input open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output valid or input closed after reset");

  // Drawn rate stays clamped
  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> rate <= 10'd999)
    else $error("shown rate above 999");

  // Rectangles are square cells
  a_square: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 11'(right - left) == 11'(bottom - top))
    else $error("rectangle is not square");

  // Hold a stalled rectangle
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled rectangle changed");

endmodule

bind fps_digit_overlay_generator fdo_checker u_fdo_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
